// File: hdl/range_cull_objective_partition_defines.svh
// Assertion macros shared by the range cull checker.
// Include this file by name; it has no dependencies of its own.
`ifndef RANGE_CULL_OBJECTIVE_PARTITION_DEFINES_SVH
`define RANGE_CULL_OBJECTIVE_PARTITION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCOP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("range cull assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RCOP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("range cull assertion failed");

`endif

// File: hdl/rcop_pkg.sv
// Package for the range cull block: field widths, codes and the queue entry type.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rcop_pkg;

	localparam int COORD_W     = 24;
	localparam int HEALTH_IN_W = 20;
	localparam int HEALTH_W    = 17;
	localparam int RADIUS_W    = 23;
	localparam int DISPLAY_W   = 32;
	localparam int SLOT_W      = 12;
	localparam int BAD_W       = 13;
	localparam int RANGE_W     = 24;
	localparam int CFG_IDX_W   = 2;
	localparam int DIFF_W      = COORD_W + 1;
	localparam int SQ_W        = 2 * COORD_W + 1;
	localparam int DIST_W      = SQ_W + 1;
	localparam int LIM_W       = 2 * RANGE_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [HEALTH_W-1:0] HEALTH_ONE = 17'd65536;
	localparam logic [1:0]          ROLE_MASK  = 2'h3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X  = 2'd0,
		CFG_ORIGIN_Y  = 2'd1,
		CFG_ORIGIN_Z  = 2'd2,
		CFG_MAX_RANGE = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		CMD_ADD   = 1'b0,
		CMD_BEGIN = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t                        cmd;
		logic                        keep;
		logic signed [COORD_W-1:0]   x;
		logic signed [COORD_W-1:0]   y;
		logic signed [COORD_W-1:0]   z;
		logic [HEALTH_W-1:0]         health;
		logic                        health_bad;
		logic [RADIUS_W-1:0]         radius;
		logic [DISPLAY_W-1:0]        display;
	} entry_t;

endpackage

// File: hdl/rcop_front.sv
// Front end: accepts entity transactions, sanitizes health and radius and runs the
// three-stage squared-distance test. Depends on rcop_pkg.
`timescale 1ns / 1ps

module rcop_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   cmd,
	input  logic signed [rcop_pkg::COORD_W-1:0]    pos_x,
	input  logic signed [rcop_pkg::COORD_W-1:0]    pos_y,
	input  logic signed [rcop_pkg::COORD_W-1:0]    pos_z,
	input  logic signed [rcop_pkg::HEALTH_IN_W-1:0] health_in,
	input  logic                                   health_not_finite,
	input  logic signed [rcop_pkg::COORD_W-1:0]    radius_in,
	input  logic                                   radius_not_finite,
	input  logic [rcop_pkg::DISPLAY_W-1:0]         display_word,
	input  logic                                   range_override,
	input  logic signed [rcop_pkg::COORD_W-1:0]    origin_x,
	input  logic signed [rcop_pkg::COORD_W-1:0]    origin_y,
	input  logic signed [rcop_pkg::COORD_W-1:0]    origin_z,
	input  logic [rcop_pkg::RANGE_W-1:0]           max_range,
	input  logic                                   q_full,
	output logic                                   q_push,
	output rcop_pkg::entry_t                       q_entry
);

	logic                                 v_s1, v_s2, v_s3;
	logic                                 en1, en2, en3;
	rcop_pkg::entry_t                     ent_in, ent_s1, ent_s2, ent_s3;
	rcop_pkg::entry_t                     ent_chk;
	logic signed [rcop_pkg::HEALTH_IN_W-1:0] hv;
	logic signed [rcop_pkg::DIFF_W-1:0]   dx_s1, dy_s1, dz_s1;
	logic signed [2*rcop_pkg::DIFF_W-1:0] px, py, pz;
	logic [rcop_pkg::SQ_W-1:0]            sqx_s2, sqy_s2, sqz_s2;
	logic [rcop_pkg::LIM_W-1:0]           lim_s2;
	logic [rcop_pkg::DIST_W-1:0]          dist_sum;

	assign en3      = !v_s3 || !q_full;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;
	assign q_push   = v_s3 && !q_full;
	assign q_entry  = ent_s3;

	always_comb begin
		hv = health_not_finite ? '0 : health_in;
		ent_in         = '0;
		ent_in.cmd     = rcop_pkg::cmd_t'(cmd);
		ent_in.keep    = range_override;
		ent_in.x       = pos_x;
		ent_in.y       = pos_y;
		ent_in.z       = pos_z;
		ent_in.health_bad = health_not_finite;
		ent_in.display = display_word;
		if (hv < 0) begin
			ent_in.health = '0;
		end else if (hv > $signed(rcop_pkg::HEALTH_IN_W'(rcop_pkg::HEALTH_ONE))) begin
			ent_in.health = rcop_pkg::HEALTH_ONE;
		end else begin
			ent_in.health = hv[rcop_pkg::HEALTH_W-1:0];
		end
		if (radius_not_finite || radius_in[rcop_pkg::COORD_W-1]) begin
			ent_in.radius = '0;
		end else begin
			ent_in.radius = radius_in[rcop_pkg::RADIUS_W-1:0];
		end
	end

	assign px       = dx_s1 * dx_s1;
	assign py       = dy_s1 * dy_s1;
	assign pz       = dz_s1 * dz_s1;
	assign dist_sum = rcop_pkg::DIST_W'(sqx_s2) + rcop_pkg::DIST_W'(sqy_s2)
		+ rcop_pkg::DIST_W'(sqz_s2);

	always_comb begin
		ent_chk      = ent_s2;
		ent_chk.keep = ent_s2.keep || (dist_sum <= rcop_pkg::DIST_W'(lim_s2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			ent_s1 <= ent_in;
			dx_s1  <= {pos_x[rcop_pkg::COORD_W-1], pos_x}
				- {origin_x[rcop_pkg::COORD_W-1], origin_x};
			dy_s1  <= {pos_y[rcop_pkg::COORD_W-1], pos_y}
				- {origin_y[rcop_pkg::COORD_W-1], origin_y};
			dz_s1  <= {pos_z[rcop_pkg::COORD_W-1], pos_z}
				- {origin_z[rcop_pkg::COORD_W-1], origin_z};
		end
		if (en2) begin
			ent_s2 <= ent_s1;
			sqx_s2 <= rcop_pkg::SQ_W'(unsigned'(px));
			sqy_s2 <= rcop_pkg::SQ_W'(unsigned'(py));
			sqz_s2 <= rcop_pkg::SQ_W'(unsigned'(pz));
			lim_s2 <= max_range * max_range;
		end
		if (en3) begin
			ent_s3 <= ent_chk;
		end
	end

endmodule

// File: hdl/rcop_queue.sv
// Short queue that decouples the distance front end from the counter back end.
// Depends on rcop_pkg.
`timescale 1ns / 1ps

module rcop_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rcop_pkg::entry_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             pop_valid,
	output rcop_pkg::entry_t pop_data
);

	rcop_pkg::entry_t            mem_q [rcop_pkg::QUEUE_DEPTH];
	logic [rcop_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [rcop_pkg::QCNT_W-1:0] cnt_q;

	assign full      = (cnt_q == rcop_pkg::QCNT_W'(rcop_pkg::QUEUE_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

// File: hdl/rcop_back.sv
// Back end: frame counters, buffer-full check, objective partitioning and the
// output register. Depends on rcop_pkg.
`timescale 1ns / 1ps

module rcop_back #(
	parameter int MAX_ENTRIES = 4096
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   q_valid,
	input  rcop_pkg::entry_t                       q_entry,
	output logic                                   q_pop,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [rcop_pkg::COORD_W-1:0]    out_x,
	output logic signed [rcop_pkg::COORD_W-1:0]    out_y,
	output logic signed [rcop_pkg::COORD_W-1:0]    out_z,
	output logic [rcop_pkg::HEALTH_W-1:0]          health_out,
	output logic [rcop_pkg::RADIUS_W-1:0]          radius_out,
	output logic [rcop_pkg::DISPLAY_W-1:0]         display_out,
	output logic                                   has_swap,
	output logic [rcop_pkg::SLOT_W-1:0]            swap_slot,
	output logic [rcop_pkg::SLOT_W-1:0]            slot_index,
	output logic [rcop_pkg::BAD_W-1:0]             bad_health_total
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

	logic             obj_seen_q, obj_seen_d;
	logic [CNT_W-1:0] first_obj_q, first_obj_d;
	logic [CNT_W-1:0] acc_q, acc_d;
	logic [CNT_W-1:0] bad_q, bad_d;
	logic             take, emit, is_obj, swap_d;
	logic             out_v_q;

	assign take      = !out_v_q || !out_stall;
	assign q_pop     = q_valid && take;
	assign out_valid = out_v_q;

	always_comb begin
		obj_seen_d  = obj_seen_q;
		first_obj_d = first_obj_q;
		acc_d       = acc_q;
		bad_d       = bad_q;
		emit        = 1'b0;
		swap_d      = 1'b0;
		is_obj      = ((q_entry.display[1:0] & rcop_pkg::ROLE_MASK) != '0);
		if (q_entry.cmd == rcop_pkg::CMD_BEGIN) begin
			obj_seen_d  = 1'b0;
			first_obj_d = '0;
			acc_d       = '0;
			bad_d       = '0;
		end else if (acc_q < MAX_CNT && q_entry.keep) begin
			emit  = 1'b1;
			acc_d = acc_q + 1'b1;
			if (q_entry.health_bad && bad_q < MAX_CNT) bad_d = bad_q + 1'b1;
			if (is_obj) begin
				if (!obj_seen_q) begin
					obj_seen_d  = 1'b1;
					first_obj_d = acc_q;
				end
			end else if (obj_seen_q) begin
				swap_d = 1'b1;
				if (first_obj_q < MAX_CNT) first_obj_d = first_obj_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_seen_q  <= 1'b0;
			first_obj_q <= '0;
			acc_q       <= '0;
			bad_q       <= '0;
			out_v_q     <= 1'b0;
		end else if (take) begin
			out_v_q <= q_pop && emit;
			if (q_pop) begin
				obj_seen_q  <= obj_seen_d;
				first_obj_q <= first_obj_d;
				acc_q       <= acc_d;
				bad_q       <= bad_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			out_x            <= q_entry.x;
			out_y            <= q_entry.y;
			out_z            <= q_entry.z;
			health_out       <= q_entry.health;
			radius_out       <= q_entry.radius;
			display_out      <= q_entry.display;
			has_swap         <= swap_d;
			swap_slot        <= swap_d ? rcop_pkg::SLOT_W'(first_obj_q) : '0;
			slot_index       <= rcop_pkg::SLOT_W'(acc_q);
			bad_health_total <= rcop_pkg::BAD_W'(bad_d);
		end
	end

endmodule

// File: hdl/range_cull_objective_partition.sv
// Top level of the range cull block: configuration registers, front end, queue
// and back end. Depends on rcop_pkg, rcop_front, rcop_queue and rcop_back.
//
// Channel   Signals                  Direction  Meaning
// in        in_valid / in_stall      sink       entity or begin-frame transaction
// out       out_valid / out_stall    source     one accepted entity instance
// cfg       cfg_valid / cfg_ready    sink       write of origin_x/y/z or max_range
//
// One transaction per cycle is sustained while no stall holds the flow; an accepted
// input passes the three distance stages and the queue before the output register.
// Reset clears the pipeline, queue, frame counters and all four registers.
// An output stall holds the output register; the four-entry queue and then the
// three front stages absorb new transactions, and in_stall rises once all are full.
`timescale 1ns / 1ps

module range_cull_objective_partition #(
	parameter int MAX_ENTRIES = 4096
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [rcop_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [rcop_pkg::COORD_W-1:0]            cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic                                    cmd,
	input  logic signed [rcop_pkg::COORD_W-1:0]     pos_x,
	input  logic signed [rcop_pkg::COORD_W-1:0]     pos_y,
	input  logic signed [rcop_pkg::COORD_W-1:0]     pos_z,
	input  logic signed [rcop_pkg::HEALTH_IN_W-1:0] health_in,
	input  logic                                    health_not_finite,
	input  logic signed [rcop_pkg::COORD_W-1:0]     radius_in,
	input  logic                                    radius_not_finite,
	input  logic [rcop_pkg::DISPLAY_W-1:0]          display_word,
	input  logic                                    range_override,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [rcop_pkg::COORD_W-1:0]     out_x,
	output logic signed [rcop_pkg::COORD_W-1:0]     out_y,
	output logic signed [rcop_pkg::COORD_W-1:0]     out_z,
	output logic [rcop_pkg::HEALTH_W-1:0]           health_out,
	output logic [rcop_pkg::RADIUS_W-1:0]           radius_out,
	output logic [rcop_pkg::DISPLAY_W-1:0]          display_out,
	output logic                                    has_swap,
	output logic [rcop_pkg::SLOT_W-1:0]             swap_slot,
	output logic [rcop_pkg::SLOT_W-1:0]             slot_index,
	output logic [rcop_pkg::BAD_W-1:0]              bad_health_total
);

	logic signed [rcop_pkg::COORD_W-1:0] origin_x_q, origin_y_q, origin_z_q;
	logic [rcop_pkg::RANGE_W-1:0]        max_range_q;
	logic                                q_push, q_full, q_pop, q_valid;
	rcop_pkg::entry_t                    push_entry, pop_entry;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			origin_z_q  <= '0;
			max_range_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (rcop_pkg::cfg_reg_t'(cfg_index))
				rcop_pkg::CFG_ORIGIN_X:  origin_x_q  <= cfg_data;
				rcop_pkg::CFG_ORIGIN_Y:  origin_y_q  <= cfg_data;
				rcop_pkg::CFG_ORIGIN_Z:  origin_z_q  <= cfg_data;
				rcop_pkg::CFG_MAX_RANGE: max_range_q <= rcop_pkg::RANGE_W'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	rcop_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.cmd               (cmd),
		.pos_x             (pos_x),
		.pos_y             (pos_y),
		.pos_z             (pos_z),
		.health_in         (health_in),
		.health_not_finite (health_not_finite),
		.radius_in         (radius_in),
		.radius_not_finite (radius_not_finite),
		.display_word      (display_word),
		.range_override    (range_override),
		.origin_x          (origin_x_q),
		.origin_y          (origin_y_q),
		.origin_z          (origin_z_q),
		.max_range         (max_range_q),
		.q_full            (q_full),
		.q_push            (q_push),
		.q_entry           (push_entry)
	);

	rcop_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_entry),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (pop_entry)
	);

	rcop_back #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.q_entry          (pop_entry),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_x            (out_x),
		.out_y            (out_y),
		.out_z            (out_z),
		.health_out       (health_out),
		.radius_out       (radius_out),
		.display_out      (display_out),
		.has_swap         (has_swap),
		.swap_slot        (swap_slot),
		.slot_index       (slot_index),
		.bad_health_total (bad_health_total)
	);

endmodule

// File: hdl/rcop_checker.sv
// Port-level checker for the range cull block and its bind to the top level.
// Depends on rcop_pkg and range_cull_objective_partition_defines.svh.
`timescale 1ns / 1ps
`include "range_cull_objective_partition_defines.svh"

module rcop_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic signed [rcop_pkg::COORD_W-1:0]  out_x,
	input  logic [rcop_pkg::HEALTH_W-1:0]        health_out,
	input  logic [rcop_pkg::DISPLAY_W-1:0]       display_out,
	input  logic                                 has_swap,
	input  logic [rcop_pkg::SLOT_W-1:0]          swap_slot,
	input  logic [rcop_pkg::SLOT_W-1:0]          slot_index
);

	// A stalled output transaction stays on the port unchanged.
	`RCOP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_x) && $stable(slot_index))

	`RCOP_ASSERT_IMPLY(a_no_swap_slot, clk, arst_n, out_valid && !has_swap, swap_slot == '0)

	`RCOP_ASSERT_IMPLY(a_health_range, clk, arst_n, out_valid, health_out <= rcop_pkg::HEALTH_ONE)

	// Only non-objective instances are ever moved in front of the objectives.
	`RCOP_ASSERT_IMPLY(a_swap_nonobj, clk, arst_n, out_valid && has_swap, (display_out[1:0] & rcop_pkg::ROLE_MASK) == '0)

endmodule

bind range_cull_objective_partition rcop_checker u_rcop_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_x       (out_x),
	.health_out  (health_out),
	.display_out (display_out),
	.has_swap    (has_swap),
	.swap_slot   (swap_slot),
	.slot_index  (slot_index)
);

// File: test/tb.sv
// Self-checking testbench for range_cull_objective_partition: directed script, then random frames.
// Expected instances come from a behavioral predictor of the range cull and slot partitioning.
// Depends on rcop_pkg and the range_cull_objective_partition top level.
`timescale 1ns / 1ps

module tb;
	import rcop_pkg::*;

	localparam int FULL_COUNT    = 4096;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 500000;

	typedef struct packed {
		cmd_t                            cmd;
		logic signed [COORD_W-1:0]       x;
		logic signed [COORD_W-1:0]       y;
		logic signed [COORD_W-1:0]       z;
		logic signed [HEALTH_IN_W-1:0]   health;
		logic                            health_bad;
		logic signed [COORD_W-1:0]       radius;
		logic                            radius_bad;
		logic [DISPLAY_W-1:0]            display;
		logic                            bypass;
	} entity_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [HEALTH_W-1:0]       health;
		logic [RADIUS_W-1:0]       radius;
		logic [DISPLAY_W-1:0]      display;
		logic                      swap;
		logic [SLOT_W-1:0]         swap_slot;
		logic [SLOT_W-1:0]         slot;
		logic [BAD_W-1:0]          bad_total;
	} instance_t;

	typedef enum bit {STEP_ENTITY, STEP_CONFIG} step_kind_t;

	typedef struct {
		step_kind_t          kind;
		cfg_reg_t            reg_id;
		logic [COORD_W-1:0]  value;
		entity_t             ent;
		bit                  typed;
		instance_t           want;
	} script_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [CFG_IDX_W-1:0]            cfg_index;
	logic [COORD_W-1:0]              cfg_data;
	logic                            in_valid;
	logic                            in_stall;
	logic                            cmd;
	logic signed [COORD_W-1:0]       pos_x;
	logic signed [COORD_W-1:0]       pos_y;
	logic signed [COORD_W-1:0]       pos_z;
	logic signed [HEALTH_IN_W-1:0]   health_in;
	logic                            health_not_finite;
	logic signed [COORD_W-1:0]       radius_in;
	logic                            radius_not_finite;
	logic [DISPLAY_W-1:0]            display_word;
	logic                            range_override;
	logic                            out_valid;
	logic                            out_stall;
	logic signed [COORD_W-1:0]       out_x;
	logic signed [COORD_W-1:0]       out_y;
	logic signed [COORD_W-1:0]       out_z;
	logic [HEALTH_W-1:0]             health_out;
	logic [RADIUS_W-1:0]             radius_out;
	logic [DISPLAY_W-1:0]            display_out;
	logic                            has_swap;
	logic [SLOT_W-1:0]               swap_slot;
	logic [SLOT_W-1:0]               slot_index;
	logic [BAD_W-1:0]                bad_health_total;

	// Predictor copy of the registers and the frame state.
	logic signed [COORD_W-1:0] view_x;
	logic signed [COORD_W-1:0] view_y;
	logic signed [COORD_W-1:0] view_z;
	logic [RANGE_W-1:0]        range_limit;
	bit                        obj_seen;
	int                        obj_front_slot;
	int                        placed_count;
	int                        bad_health_seen;

	instance_t   pending_instances[$];
	script_row_t script[$];
	int          fail_count = 0;
	int          send_gap_max = 9;
	int          recv_gap_max = 9;
	int          hold_request = 0;
	int unsigned cycle_count = 0;

	range_cull_objective_partition #(.MAX_ENTRIES(FULL_COUNT)) dut (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	function automatic longint unsigned sq_gap(logic signed [COORD_W-1:0] p,
			logic signed [COORD_W-1:0] o);
		longint d;
		d = longint'(p) - longint'(o);
		return longint'(d * d);
	endfunction

	function automatic void cull_entity(input entity_t e, output bit emitted,
			output instance_t r);
		longint unsigned dist_sq;
		longint unsigned lim;
		longint hv;
		longint rv;
		emitted = 1'b0;
		r = '0;
		if (e.cmd == CMD_BEGIN) begin
			obj_seen = 1'b0;
			obj_front_slot = 0;
			placed_count = 0;
			bad_health_seen = 0;
			return;
		end
		if (placed_count >= FULL_COUNT)
			return;
		dist_sq = sq_gap(e.x, view_x) + sq_gap(e.y, view_y) + sq_gap(e.z, view_z);
		lim = longint'(range_limit) * longint'(range_limit);
		if (!e.bypass && dist_sq > lim)
			return;
		if (e.health_bad) begin
			hv = 0;
			if (bad_health_seen < FULL_COUNT)
				bad_health_seen++;
		end else begin
			hv = longint'(e.health);
		end
		if (hv < 0)
			hv = 0;
		if (hv > longint'(HEALTH_ONE))
			hv = longint'(HEALTH_ONE);
		rv = e.radius_bad ? 0 : longint'(e.radius);
		if (rv < 0)
			rv = 0;
		r.slot = SLOT_W'(placed_count);
		if ((e.display[1:0] & ROLE_MASK) != 2'b00) begin
			if (!obj_seen) begin
				obj_seen = 1'b1;
				obj_front_slot = placed_count;
			end
		end else if (obj_seen) begin
			r.swap = 1'b1;
			r.swap_slot = SLOT_W'(obj_front_slot);
			if (obj_front_slot < FULL_COUNT)
				obj_front_slot++;
		end
		placed_count++;
		r.x = e.x;
		r.y = e.y;
		r.z = e.z;
		r.health = HEALTH_W'(hv);
		r.radius = RADIUS_W'(rv);
		r.display = e.display;
		r.bad_total = BAD_W'(bad_health_seen);
		emitted = 1'b1;
	endfunction

	function automatic void field_check(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic void script_entity(cmd_t c, int x, int y, int z, int hlt, bit hbad,
			int rad, bit rbad, logic [31:0] disp, bit bp);
		script_row_t s;
		s.kind = STEP_ENTITY;
		s.reg_id = CFG_ORIGIN_X;
		s.value = '0;
		s.ent.cmd = c;
		s.ent.x = COORD_W'(x);
		s.ent.y = COORD_W'(y);
		s.ent.z = COORD_W'(z);
		s.ent.health = HEALTH_IN_W'(hlt);
		s.ent.health_bad = hbad;
		s.ent.radius = COORD_W'(rad);
		s.ent.radius_bad = rbad;
		s.ent.display = disp;
		s.ent.bypass = bp;
		s.typed = 1'b0;
		s.want = '0;
		script.push_back(s);
	endfunction

	function automatic void script_result(bit sw, int swap_at, int slot_at, int hlt, int rad,
			int bad);
		instance_t w;
		int last;
		last = script.size() - 1;
		w.x = script[last].ent.x;
		w.y = script[last].ent.y;
		w.z = script[last].ent.z;
		w.display = script[last].ent.display;
		w.health = HEALTH_W'(hlt);
		w.radius = RADIUS_W'(rad);
		w.swap = sw;
		w.swap_slot = SLOT_W'(swap_at);
		w.slot = SLOT_W'(slot_at);
		w.bad_total = BAD_W'(bad);
		script[last].want = w;
		script[last].typed = 1'b1;
	endfunction

	function automatic void script_config(cfg_reg_t id, int value);
		script_row_t s;
		s.kind = STEP_CONFIG;
		s.reg_id = id;
		s.value = COORD_W'(value);
		s.ent = '0;
		s.typed = 1'b0;
		s.want = '0;
		script.push_back(s);
	endfunction

	function automatic int jitter(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic [COORD_W-1:0] pick_origin();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
			2: return COORD_W'($urandom_range(0, 2000)) - 24'd1000;
			default: return COORD_W'($urandom);
		endcase
	endfunction

	function automatic entity_t rand_entity();
		entity_t e;
		int span;
		span = int'(range_limit) * 3 / 4 + 2;
		e.cmd = ($urandom_range(0, 39) == 0) ? CMD_BEGIN : CMD_ADD;
		case ($urandom_range(0, 3))
			0: begin
				e.x = COORD_W'($urandom);
				e.y = COORD_W'($urandom);
				e.z = COORD_W'($urandom);
			end
			1: begin
				e.x = COORD_W'(view_x + range_limit + $urandom_range(0, 1));
				e.y = view_y;
				e.z = view_z;
			end
			default: begin
				e.x = COORD_W'(view_x + jitter(span));
				e.y = COORD_W'(view_y + jitter(span));
				e.z = COORD_W'(view_z + jitter(span));
			end
		endcase
		case ($urandom_range(0, 3))
			0: e.health = HEALTH_IN_W'($urandom);
			1: e.health = HEALTH_IN_W'($urandom_range(0, 65536));
			2: e.health = HEALTH_IN_W'(65535 + $urandom_range(0, 2));
			default: e.health = HEALTH_IN_W'($urandom_range(0, 2) - 1);
		endcase
		case ($urandom_range(0, 2))
			0: e.radius = COORD_W'($urandom);
			1: e.radius = COORD_W'($urandom_range(0, 1000));
			default: e.radius = COORD_W'($urandom_range(0, 2) - 1);
		endcase
		e.health_bad = ($urandom_range(0, 7) == 0);
		e.radius_bad = ($urandom_range(0, 7) == 0);
		e.display = $urandom;
		e.bypass = ($urandom_range(0, 3) == 0);
		return e;
	endfunction

	task automatic send_entity(input entity_t e, input bit typed, input instance_t want);
		int gap;
		bit emitted;
		instance_t got;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= e.cmd;
		pos_x <= e.x;
		pos_y <= e.y;
		pos_z <= e.z;
		health_in <= e.health;
		health_not_finite <= e.health_bad;
		radius_in <= e.radius;
		radius_not_finite <= e.radius_bad;
		display_word <= e.display;
		range_override <= e.bypass;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		cull_entity(e, emitted, got);
		if (emitted)
			pending_instances.push_back(typed ? want : got);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_instances.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(cfg_reg_t id, logic [COORD_W-1:0] value);
		cfg_index <= id;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (id)
			CFG_ORIGIN_X: view_x = value;
			CFG_ORIGIN_Y: view_y = value;
			CFG_ORIGIN_Z: view_z = value;
			CFG_MAX_RANGE: range_limit = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic run_phase(int count, int send_max, int recv_max, int hold);
		send_gap_max = send_max;
		recv_gap_max = recv_max;
		hold_request = hold;
		repeat (count) send_entity(rand_entity(), 1'b0, '0);
		settle();
	endtask

	initial begin : result_side
		int wait_left;
		instance_t want;
		wait_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_instances.size() == 0) begin
					$error("instance for slot %0d arrived with none expected", slot_index);
					fail_count++;
				end else begin
					want = pending_instances.pop_front();
					field_check("out_x", want.x, out_x);
					field_check("out_y", want.y, out_y);
					field_check("out_z", want.z, out_z);
					field_check("health_out", want.health, health_out);
					field_check("radius_out", want.radius, radius_out);
					field_check("display_out", want.display, display_out);
					field_check("has_swap", want.swap, has_swap);
					field_check("swap_slot", want.swap_slot, swap_slot);
					field_check("slot_index", want.slot, slot_index);
					field_check("bad_health_total", want.bad_total, bad_health_total);
				end
				wait_left = $urandom_range(0, recv_gap_max);
			end
			if (hold_request > 0) begin
				wait_left = hold_request;
				hold_request = 0;
			end
			out_stall <= (wait_left > 0);
			if (wait_left > 0)
				wait_left--;
		end
	end

	initial begin
		logic [RANGE_W-1:0] lim_value;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_ORIGIN_X;
		cfg_data <= '0;
		in_valid <= 1'b0;
		cmd <= CMD_ADD;
		pos_x <= '0;
		pos_y <= '0;
		pos_z <= '0;
		health_in <= '0;
		health_not_finite <= 1'b0;
		radius_in <= '0;
		radius_not_finite <= 1'b0;
		display_word <= '0;
		range_override <= 1'b0;
		view_x = '0;
		view_y = '0;
		view_z = '0;
		range_limit = '0;
		obj_seen = 1'b0;
		obj_front_slot = 0;
		placed_count = 0;
		bad_health_seen = 0;

		// With the registers at reset only entities at the origin or bypassed pass.
		script_entity(CMD_BEGIN, 0, 0, 0, 0, 0, 0, 0, 32'h0, 0);
		script_entity(CMD_ADD, 0, 0, 0, 65536, 0, 5, 0, 32'h0, 0);
		script_result(0, 0, 0, 65536, 5, 0);
		script_entity(CMD_ADD, 1, 0, 0, 100, 0, 7, 0, 32'h10, 0);
		script_entity(CMD_ADD, -8388608, -8388608, -8388608, 524287, 0, 8388607, 0,
			32'h1, 1);
		script_result(0, 0, 1, 65536, 8388607, 0);
		script_entity(CMD_ADD, 8388607, 8388607, 8388607, -524288, 0, -8388608, 0,
			32'hFFFFFFFE, 1);
		script_result(0, 0, 2, 0, 0, 0);
		script_entity(CMD_ADD, 0, 0, 0, 524287, 1, 1234, 1, 32'h0, 0);
		script_result(1, 1, 3, 0, 0, 1);
		script_entity(CMD_ADD, 0, 0, 0, 32768, 0, 0, 0, 32'h4, 1);
		script_result(1, 2, 4, 32768, 0, 1);
		script_entity(CMD_ADD, 0, 0, 0, -1, 0, 99, 1, 32'h2, 0);
		script_result(0, 0, 5, 0, 0, 1);
		script_entity(CMD_BEGIN, 0, 0, 0, 0, 0, 0, 0, 32'h0, 0);
		script_entity(CMD_ADD, 0, 0, 0, 65537, 0, 1, 0, 32'h3, 0);
		script_result(0, 0, 0, 65536, 1, 0);
		script_entity(CMD_ADD, 0, 0, 0, 200, 1, 42, 0, 32'hFFFFFFFC, 0);
		script_result(1, 0, 1, 0, 42, 1);
		// A distance exactly on the limit passes, one unit beyond is dropped.
		script_config(CFG_ORIGIN_X, 100);
		script_config(CFG_ORIGIN_Y, -200);
		script_config(CFG_ORIGIN_Z, 300);
		script_config(CFG_MAX_RANGE, 5);
		script_entity(CMD_ADD, 103, -196, 300, 1000, 0, 10, 0, 32'h8, 0);
		script_entity(CMD_ADD, 103, -196, 301, 1000, 0, 10, 0, 32'h9, 0);
		script_entity(CMD_ADD, 103, -196, 301, 1000, 0, 10, 0, 32'hA, 1);
		script_config(CFG_ORIGIN_X, -8388608);
		script_config(CFG_ORIGIN_Y, 0);
		script_config(CFG_ORIGIN_Z, 0);
		script_config(CFG_MAX_RANGE, 16777215);
		script_entity(CMD_ADD, 8388607, 0, 0, 40000, 0, 77, 0, 32'h0, 0);
		script_entity(CMD_ADD, 8388607, 1, 0, 40000, 0, 77, 0, 32'h1, 0);
		script_entity(CMD_ADD, 8388607, 8388607, 8388607, 40000, 0, 77, 0, 32'h5, 1);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].kind == STEP_CONFIG) begin
				settle();
				write_register(script[i].reg_id, script[i].value);
			end else begin
				send_entity(script[i].ent, script[i].typed, script[i].want);
			end
		end
		settle();

		for (int p = 0; p < 8; p++) begin
			write_register(CFG_ORIGIN_X, pick_origin());
			write_register(CFG_ORIGIN_Y, pick_origin());
			write_register(CFG_ORIGIN_Z, pick_origin());
			case (p % 5)
				0: lim_value = '0;
				1: lim_value = '1;
				2: lim_value = RANGE_W'($urandom_range(0, 255));
				3: lim_value = RANGE_W'($urandom_range(0, 65536));
				default: lim_value = RANGE_W'($urandom);
			endcase
			write_register(CFG_MAX_RANGE, lim_value);
			run_phase(112, (p % 2 == 1) ? 0 : 9, (p % 4 >= 2) ? 0 : 9, (p == 5) ? 150 : 0);
		end

		if (fail_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
